/* rtl/core/hsir_pkg.sv */
// ----------------------------------------------------------------------------
// hsir_pkg
// Types, register indexes and helper functions of the humidity sensor reader.
// ----------------------------------------------------------------------------
package hsir_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 3'd0,
        CFG_READ_FUNCTION  = 3'd1,
        CFG_START_REGISTER = 3'd2,
        CFG_REGISTER_COUNT = 3'd3,
        CFG_HALF_BIT_TICKS = 3'd4,
        CFG_WAKE_HOLD      = 3'd5,
        CFG_COMMAND_WAIT   = 3'd6,
        CFG_READ_WAIT      = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_TX_LO, PH_TX_HI, PH_AK_LO, PH_AK_HI,
        PH_WAKE_WAIT, PH_SP_A, PH_SP_B, PH_CMD_WAIT, PH_RD_WAIT, PH_RX_LO,
        PH_RX_HI, PH_MA_LO, PH_MA_HI, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        XF_WAKE, XF_WRITE, XF_READ
    } t_xfer;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  read_function;
        logic [7:0]  start_register;
        logic [7:0]  register_count;
        logic [15:0] half_bit_ticks;
        logic [15:0] wake_hold_ticks;
        logic [15:0] command_wait_ticks;
        logic [15:0] read_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] temperature;
        logic [7:0] humidity;
        logic       crc_ok;
        logic       ack_error;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } t_res;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    // ceil(2^19 / 10), exact quotient for any 16-bit dividend
    localparam logic [16:0] DIV10_MUL = 17'd52429;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] div10_low(input logic [15:0] x);
        logic [32:0] p;
        p = {17'd0, x} * {16'd0, DIV10_MUL};
        return p[26:19];
    endfunction

endpackage

/* rtl/core/hsir_core.sv */
// ----------------------------------------------------------------------------
// hsir_core
// Bus sequencer: state registers and the next-state logic of one tick.
// ----------------------------------------------------------------------------
module hsir_core
    import hsir_pkg::*;
#(
    parameter int RESPONSE_BYTES = 8,
    parameter int COMMAND_BYTES  = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  logic i_req,
    input  logic i_sda,
    input  t_cfg i_cfg,
    output t_res o_res
);

    localparam int DEPTH = (RESPONSE_BYTES > 6) ? RESPONSE_BYTES : 6;
    localparam int IDXW  = $clog2(DEPTH);
    localparam logic [3:0] LAST_BYTE = 4'(RESPONSE_BYTES - 1);
    localparam logic [3:0] CRC_BYTES = 4'(RESPONSE_BYTES - 2);
    localparam logic [3:0] CMD_BYTES = 4'(COMMAND_BYTES);

    t_phase      r_phase, n_phase;
    t_xfer       r_xfer, n_xfer;
    logic [15:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [3:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_crc, n_crc;
    logic        r_err, n_err;
    logic        r_crcf, n_crcf;
    logic [7:0]  r_hum, n_hum;
    logic [7:0]  r_temp, n_temp;
    logic [7:0]  r_store [DEPTH];
    logic        store_we;
    logic [7:0]  rx_byte;

    logic [15:0] seg_raw;
    logic [15:0] seg_len;
    logic        seg_end;
    logic        crc_match;
    logic        last_now;
    logic        n_last;
    logic [7:0]  cmd_byte;

    always_comb begin
        unique case (r_phase)
            PH_WAKE_WAIT: seg_raw = i_cfg.wake_hold_ticks;
            PH_CMD_WAIT:  seg_raw = i_cfg.command_wait_ticks;
            PH_RD_WAIT:   seg_raw = i_cfg.read_wait_ticks;
            default:      seg_raw = i_cfg.half_bit_ticks;
        endcase
        seg_len = (seg_raw == 16'd0) ? 16'd1 : seg_raw;
        seg_end = ({1'b0, r_tick} + 17'd1) >= {1'b0, seg_len};
    end

    assign rx_byte   = {r_shift[6:0], i_sda};
    assign last_now  = r_byte >= LAST_BYTE;
    assign crc_match = (r_store[IDXW'(RESPONSE_BYTES - 2)] == r_crc[7:0])
                    && (r_store[IDXW'(RESPONSE_BYTES - 1)] == r_crc[15:8]);

    always_comb begin
        unique case (r_byte)
            4'd0:    cmd_byte = i_cfg.read_function;
            4'd1:    cmd_byte = i_cfg.start_register;
            default: cmd_byte = i_cfg.register_count;
        endcase
    end

    // next state for one tick
    always_comb begin
        n_phase  = r_phase;
        n_xfer   = r_xfer;
        n_tick   = r_tick + 16'd1;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_crc    = r_crc;
        n_err    = r_err;
        n_crcf   = r_crcf;
        n_hum    = r_hum;
        n_temp   = r_temp;
        store_we = 1'b0;
        if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
            n_tick = 16'd0;
            if (i_req) begin
                n_err   = 1'b0;
                n_xfer  = XF_WAKE;
                n_byte  = 4'd0;
                n_bit   = 4'd0;
                n_shift = i_cfg.device_address;
                n_phase = PH_ST_A;
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (seg_end) begin
            n_tick = 16'd0;
            unique case (r_phase)
                PH_ST_A:  n_phase = PH_ST_B;
                PH_ST_B: begin
                    n_bit   = 4'd0;
                    n_phase = PH_TX_LO;
                end
                PH_TX_LO: n_phase = PH_TX_HI;
                PH_TX_HI: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    n_phase = (n_bit >= 4'd8) ? PH_AK_LO : PH_TX_LO;
                end
                PH_AK_LO: n_phase = PH_AK_HI;
                PH_AK_HI: begin
                    if (r_xfer == XF_WAKE) begin
                        n_phase = PH_WAKE_WAIT;
                    end else if (i_sda) begin
                        n_err   = 1'b1;
                        n_phase = PH_SP_A;
                    end else if (r_xfer == XF_WRITE) begin
                        n_byte = r_byte + 4'd1;
                        if (n_byte > CMD_BYTES) begin
                            n_phase = PH_SP_A;
                        end else begin
                            n_shift = cmd_byte;
                            n_bit   = 4'd0;
                            n_phase = PH_TX_LO;
                        end
                    end else begin
                        n_byte  = 4'd0;
                        n_bit   = 4'd0;
                        n_crc   = CRC_INIT;
                        n_phase = (i_cfg.read_wait_ticks != 16'd0) ? PH_RD_WAIT : PH_RX_LO;
                    end
                end
                PH_WAKE_WAIT: n_phase = PH_SP_A;
                PH_SP_A:      n_phase = PH_SP_B;
                PH_SP_B: begin
                    if (r_err) begin
                        n_phase = PH_DONE;
                    end else if (r_xfer == XF_WAKE) begin
                        n_xfer  = XF_WRITE;
                        n_byte  = 4'd0;
                        n_bit   = 4'd0;
                        n_shift = i_cfg.device_address;
                        n_phase = PH_ST_A;
                    end else if (r_xfer == XF_WRITE) begin
                        n_phase = PH_CMD_WAIT;
                    end else begin
                        n_crcf = crc_match;
                        if (crc_match) begin
                            n_hum  = div10_low({r_store[2], r_store[3]});
                            n_temp = div10_low({r_store[4], r_store[5]});
                        end
                        n_phase = PH_DONE;
                    end
                end
                PH_CMD_WAIT: begin
                    n_xfer  = XF_READ;
                    n_byte  = 4'd0;
                    n_bit   = 4'd0;
                    n_shift = i_cfg.device_address | 8'h01;
                    n_phase = PH_ST_A;
                end
                PH_RD_WAIT: begin
                    n_bit   = 4'd0;
                    n_phase = PH_RX_LO;
                end
                PH_RX_LO: n_phase = PH_RX_HI;
                PH_RX_HI: begin
                    n_shift = rx_byte;
                    n_bit   = r_bit + 4'd1;
                    if (n_bit >= 4'd8) begin
                        store_we = 1'b1;
                        if (r_byte < CRC_BYTES) begin
                            n_crc = crc_byte(r_crc, rx_byte);
                        end
                        n_phase = PH_MA_LO;
                    end else begin
                        n_phase = PH_RX_LO;
                    end
                end
                PH_MA_LO: n_phase = PH_MA_HI;
                PH_MA_HI: begin
                    if (last_now) begin
                        n_phase = PH_SP_A;
                    end else begin
                        n_byte  = r_byte + 4'd1;
                        n_bit   = 4'd0;
                        n_phase = PH_RX_LO;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // drive levels from the state after this tick
    always_comb begin
        n_last            = n_byte >= LAST_BYTE;
        o_res.scl_level   = 1'b1;
        o_res.sda_release = 1'b1;
        unique case (n_phase)
            PH_ST_B:  o_res.sda_release = 1'b0;
            PH_TX_LO: begin
                o_res.scl_level   = 1'b0;
                o_res.sda_release = n_shift[7];
            end
            PH_TX_HI: o_res.sda_release = n_shift[7];
            PH_AK_LO, PH_WAKE_WAIT, PH_RD_WAIT, PH_RX_LO: o_res.scl_level = 1'b0;
            PH_SP_A: begin
                o_res.scl_level   = 1'b0;
                o_res.sda_release = 1'b0;
            end
            PH_SP_B:  o_res.sda_release = 1'b0;
            PH_MA_LO: begin
                o_res.scl_level   = 1'b0;
                o_res.sda_release = n_last;
            end
            PH_MA_HI: o_res.sda_release = n_last;
            default: ;
        endcase
        o_res.busy_res    = (n_phase != PH_IDLE) && (n_phase != PH_DONE);
        o_res.done_res    = n_phase == PH_DONE;
        o_res.ack_error   = n_err;
        o_res.crc_ok      = n_crcf;
        o_res.humidity    = n_hum;
        o_res.temperature = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_xfer  <= XF_WAKE;
            r_tick  <= 16'd0;
            r_bit   <= 4'd0;
            r_byte  <= 4'd0;
            r_shift <= 8'd0;
            r_crc   <= CRC_INIT;
            r_err   <= 1'b0;
            r_crcf  <= 1'b0;
            r_hum   <= 8'd0;
            r_temp  <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_xfer  <= n_xfer;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_crc   <= n_crc;
            r_err   <= n_err;
            r_crcf  <= n_crcf;
            r_hum   <= n_hum;
            r_temp  <= n_temp;
        end
    end

    // response bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_byte[IDXW-1:0]] <= rx_byte;
        end
    end

`ifndef ASSERT_OFF
    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == 16'd0))
        else $error("tick count not cleared in idle");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TX_LO || r_phase == PH_TX_HI || r_phase == PH_RX_LO
         || r_phase == PH_RX_HI) |-> (r_bit < 4'd8))
        else $error("bit count out of range");
    a_read_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_xfer == XF_READ && (r_phase == PH_RX_LO || r_phase == PH_RX_HI))
        |-> (r_byte <= LAST_BYTE))
        else $error("read byte count beyond response");
`endif

endmodule

/* rtl/core/humidity_sensor_i2c_reader_top.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_i2c_reader_top
// Tick-driven I2C reader for a temperature and humidity sensor.
// ----------------------------------------------------------------------------
// Every accepted input item is one bus tick and produces exactly one result
// item carrying the SCL/SDA levels, status and latest readings after that
// tick. An item is accepted every clock cycle: the sequencer state advances
// in one pass of logic and the result sits in an output register, so the
// input stalls only while that register holds an item not yet taken. A
// measurement is a wake transaction, a command write, a wait, an eight-byte
// read and a CRC-16 check; its length in ticks follows the timing registers.
module humidity_sensor_i2c_reader_top
    import hsir_pkg::*;
#(
    parameter int RESPONSE_BYTES = 8,
    parameter int COMMAND_BYTES  = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // start_request, sda_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // scl_level, sda_release, busy_res, done_res, ack_error, crc_ok,
    // humidity[7:0], temperature[7:0]
    output logic [23:0]           m_axis_tdata
);

    t_cfg  r_cfg;
    t_res  res;
    t_res  r_res;
    logic  r_valid;
    logic  step;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address     <= 8'hB8;
            r_cfg.read_function      <= 8'h03;
            r_cfg.start_register     <= 8'h00;
            r_cfg.register_count     <= 8'h04;
            r_cfg.half_bit_ticks     <= 16'd10;
            r_cfg.wake_hold_ticks    <= 16'd2000;
            r_cfg.command_wait_ticks <= 16'd2000;
            r_cfg.read_wait_ticks    <= 16'd30;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_DEVICE_ADDRESS: r_cfg.device_address     <= i_cfg_wdata[7:0];
                CFG_READ_FUNCTION:  r_cfg.read_function      <= i_cfg_wdata[7:0];
                CFG_START_REGISTER: r_cfg.start_register     <= i_cfg_wdata[7:0];
                CFG_REGISTER_COUNT: r_cfg.register_count     <= i_cfg_wdata[7:0];
                CFG_HALF_BIT_TICKS: r_cfg.half_bit_ticks     <= i_cfg_wdata;
                CFG_WAKE_HOLD:      r_cfg.wake_hold_ticks    <= i_cfg_wdata;
                CFG_COMMAND_WAIT:   r_cfg.command_wait_ticks <= i_cfg_wdata;
                CFG_READ_WAIT:      r_cfg.read_wait_ticks    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    hsir_core #(
        .RESPONSE_BYTES (RESPONSE_BYTES),
        .COMMAND_BYTES  (COMMAND_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (s_axis_tdata[0]),
        .i_sda   (s_axis_tdata[1]),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_res};

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_res.done_res && r_res.busy_res))
        else $error("done and busy together");
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.busy_res) |-> (r_res.scl_level && r_res.sda_release))
        else $error("bus driven while not busy");
    a_no_result_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !r_valid)
        else $error("result valid right after reset");
`endif

endmodule
